### sv/byte_ring_fifo_macros.svh
// Assertion macros shared by the byte ring FIFO modules.
`ifndef BYTE_RING_FIFO_MACROS_SVH
`define BYTE_RING_FIFO_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/brf_pkg.sv
// Shared constants, types and operation codes of the byte ring FIFO.
`default_nettype none

package brf_pkg;

  localparam int DEPTH   = 4096;
  localparam int MAX_RUN = 64;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int RUN_W  = 7;
  localparam int CLMP_W = $clog2(MAX_RUN + 1);
  localparam int CNT_W  = 12;
  localparam int BYTE_W = 8;
  localparam int FUNC_W = 3;
  localparam int WIDE_W = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;

  localparam logic [FUNC_W-1:0] FUNC_PUSH    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DISCARD = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd4;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_PEEK,
    OP_SKIP,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] data;
    logic [CLMP_W-1:0] run;
    logic [CNT_W-1:0]  skip;
  } cmd_t;

endpackage

`default_nettype wire

### sv/brf_front.sv
// Front stage: accepts transactions, decodes the operation and saturates the run.
`default_nettype none

module brf_front import brf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire logic [BYTE_W-1:0] push_byte_i,
  input  wire logic [RUN_W-1:0]  run_length_i,
  input  wire logic [CNT_W-1:0]  skip_length_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output cmd_t                   cmd_o
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic take;

  always_comb begin
    in_ready_o = !valid_q || cmd_ready_i;
    take       = in_valid_i && in_ready_o;
    valid_d    = valid_q;
    cmd_d      = cmd_q;
    if (take) begin
      valid_d    = 1'b1;
      cmd_d.data = push_byte_i;
      cmd_d.skip = skip_length_i;
      if ({1'b0, run_length_i} > (RUN_W + 1)'(MAX_RUN)) begin
        cmd_d.run = CLMP_W'(MAX_RUN);
      end else begin
        cmd_d.run = CLMP_W'(run_length_i);
      end
      case (func_i)
        FUNC_PUSH:    cmd_d.op = OP_PUSH;
        FUNC_POP:     cmd_d.op = OP_POP;
        FUNC_PEEK:    cmd_d.op = OP_PEEK;
        FUNC_DISCARD: cmd_d.op = OP_SKIP;
        FUNC_CLEAR:   cmd_d.op = OP_CLEAR;
        default:      cmd_d.op = OP_NOP;
      endcase
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

`default_nettype wire

### sv/brf_cmd_queue.sv
// Two-entry command queue between the front stage and the execution engine.
`default_nettype none
`include "byte_ring_fifo_macros.svh"

module brf_cmd_queue import brf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  cmd_t      in_cmd_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cmd_t      out_cmd_o
);

  cmd_t       entries_q [2];
  logic       wr_idx_q, wr_idx_d;
  logic       rd_idx_q, rd_idx_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  always_comb begin
    in_ready_o  = (count_q != 2'd2);
    out_valid_o = (count_q != 2'd0);
    out_cmd_o   = entries_q[rd_idx_q];
    push        = in_valid_i && in_ready_o;
    pop         = out_valid_o && out_ready_i;
    wr_idx_d    = push ? !wr_idx_q : wr_idx_q;
    rd_idx_d    = pop ? !rd_idx_q : rd_idx_q;
    count_d     = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= 1'b0;
      rd_idx_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_idx_q] <= in_cmd_i;
    end
  end

  `BRF_ASSERT_NOW(a_count_range, 1'b1, count_q != 2'd3, "queue count out of range")
  `BRF_ASSERT_NOW(a_idx_track, count_q == 2'd0 || count_q == 2'd2, wr_idx_q == rd_idx_q,
                  "queue indexes disagree with count")

endmodule

`default_nettype wire

### sv/brf_back.sv
// Execution engine: ring store, pointers, run sequencer and output register.
`default_nettype none
`include "byte_ring_fifo_macros.svh"

module brf_back import brf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_ready_o,
  input  cmd_t                   cmd_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [BYTE_W-1:0]      out_byte_o,
  output logic                   byte_valid_o,
  output logic [CNT_W-1:0]       moved_count_o,
  output logic [CNT_W-1:0]       used_count_o,
  output logic [CNT_W-1:0]       free_count_o,
  output logic [CNT_W-1:0]       contiguous_read_o,
  output logic [CNT_W-1:0]       contiguous_write_o,
  output logic                   last_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ONE  = 2'd1;
  localparam logic [1:0] S_BYTE = 2'd2;

  localparam logic [PTR_W:0]    DEPTH_X = (PTR_W + 1)'(DEPTH);
  localparam logic [PTR_W-1:0]  LAST_IX = PTR_W'(DEPTH - 1);
  localparam logic [CLMP_W-1:0] ONE_RUN = CLMP_W'(1);

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr,
                                               input logic [PTR_W-1:0] n);
    logic [PTR_W:0] s;
    s = {1'b0, ptr} + {1'b0, n};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[PTR_W-1:0];
  endfunction

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  logic [1:0]        state_q, state_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  addr_q, addr_d;
  logic [CLMP_W-1:0] remain_q, remain_d;
  logic [CNT_W-1:0]  moved_q, moved_d;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q;
  logic              byte_valid_q;
  logic [CNT_W-1:0]  out_moved_q, used_q, free_q, cread_q, cwrite_q;
  logic              last_q;

  logic              take, slot_free, load, load_byte, load_last;
  logic              we, rd_en;
  logic [PTR_W-1:0]  rd_addr, next_addr, run_n, skip_n;
  logic [PTR_W:0]    used, free, cread, cwrite;

  always_comb begin
    if (wr_ptr_q >= rd_ptr_q) begin
      used = {1'b0, wr_ptr_q} - {1'b0, rd_ptr_q};
    end else begin
      used = {1'b0, wr_ptr_q} + DEPTH_X - {1'b0, rd_ptr_q};
    end
    free = DEPTH_X - (PTR_W + 1)'(1) - used;
    if (rd_ptr_q == wr_ptr_q) begin
      cread = '0;
    end else if (rd_ptr_q > wr_ptr_q) begin
      cread = DEPTH_X - {1'b0, rd_ptr_q};
    end else begin
      cread = {1'b0, wr_ptr_q} - {1'b0, rd_ptr_q};
    end
    if (rd_ptr_q > wr_ptr_q) begin
      cwrite = free;
    end else if (rd_ptr_q == '0) begin
      cwrite = DEPTH_X - {1'b0, wr_ptr_q} - (PTR_W + 1)'(1);
    end else begin
      cwrite = DEPTH_X - {1'b0, wr_ptr_q};
    end

    if (WIDE_W'(cmd_i.run) > WIDE_W'(used)) begin
      run_n = used[PTR_W-1:0];
    end else begin
      run_n = PTR_W'(cmd_i.run);
    end
    if (WIDE_W'(cmd_i.skip) > WIDE_W'(used)) begin
      skip_n = used[PTR_W-1:0];
    end else begin
      skip_n = PTR_W'(cmd_i.skip);
    end

    next_addr = (addr_q == LAST_IX) ? '0 : addr_q + PTR_W'(1);
    slot_free = !out_valid_q || out_ready_i;
    cmd_ready_o = (state_q == S_IDLE);
    take      = cmd_valid_i && cmd_ready_o;

    state_d   = state_q;
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    addr_d    = addr_q;
    remain_d  = remain_q;
    moved_d   = moved_q;
    we        = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = next_addr;
    load      = 1'b0;
    load_byte = 1'b0;
    load_last = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (take) begin
          state_d = S_ONE;
          moved_d = '0;
          case (cmd_i.op)
            OP_PUSH: begin
              if (free != '0) begin
                we       = 1'b1;
                wr_ptr_d = advance(wr_ptr_q, PTR_W'(1));
                moved_d  = CNT_W'(1);
              end
            end
            OP_POP, OP_PEEK: begin
              if (run_n != '0) begin
                moved_d  = CNT_W'(run_n);
                remain_d = CLMP_W'(run_n);
                rd_en    = 1'b1;
                rd_addr  = rd_ptr_q;
                addr_d   = rd_ptr_q;
                state_d  = S_BYTE;
                if (cmd_i.op == OP_POP) begin
                  rd_ptr_d = advance(rd_ptr_q, run_n);
                end
              end
            end
            OP_SKIP: begin
              rd_ptr_d = advance(rd_ptr_q, skip_n);
              moved_d  = CNT_W'(skip_n);
            end
            OP_CLEAR: begin
              rd_ptr_d = '0;
              wr_ptr_d = '0;
            end
            default: begin
              moved_d = '0;
            end
          endcase
        end
      end
      S_ONE: begin
        if (slot_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_BYTE: begin
        if (slot_free) begin
          load      = 1'b1;
          load_byte = 1'b1;
          load_last = (remain_q == ONE_RUN);
          remain_d  = remain_q - ONE_RUN;
          if (remain_q != ONE_RUN) begin
            rd_en  = 1'b1;
            addr_d = next_addr;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    remain_q <= remain_d;
    moved_q  <= moved_d;
    if (load) begin
      out_byte_q   <= load_byte ? rdata_q : '0;
      byte_valid_q <= load_byte;
      out_moved_q  <= moved_q;
      used_q       <= CNT_W'(used);
      free_q       <= CNT_W'(free);
      cread_q      <= CNT_W'(cread);
      cwrite_q     <= CNT_W'(cwrite);
      last_q       <= load_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_ptr_q] <= cmd_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_byte_o         = out_byte_q;
  assign byte_valid_o       = byte_valid_q;
  assign moved_count_o      = out_moved_q;
  assign used_count_o       = used_q;
  assign free_count_o       = free_q;
  assign contiguous_read_o  = cread_q;
  assign contiguous_write_o = cwrite_q;
  assign last_o             = last_q;

  `BRF_ASSERT_NOW(a_ptr_range, 1'b1,
                  {1'b0, rd_ptr_q} < DEPTH_X && {1'b0, wr_ptr_q} < DEPTH_X,
                  "ring pointer beyond store depth")
  `BRF_ASSERT_NOW(a_run_left, state_q == S_BYTE, remain_q != '0,
                  "byte run active with nothing left")
  `BRF_ASSERT_NEXT(a_stall_hold, state_q == S_BYTE && !slot_free,
                   $stable(addr_q) && $stable(remain_q),
                   "byte run advanced while output stalled")

endmodule

`default_nettype wire

### sv/byte_ring_fifo.sv
// Byte ring FIFO top level: front stage, command queue and execution engine.
// A byte FIFO of DEPTH-1 bytes in a DEPTH-slot ring (one slot stays empty).
// Each input transaction carries one operation: push, pop, peek, discard or
// clear. Pop and peek return one output transaction per byte (up to MAX_RUN,
// capped at the stored count) with last on the final one; every other
// operation, and an empty pop or peek, returns exactly one. Every output
// reports the fill state after the whole operation. Operations pass through a
// registered decode stage and a two-entry queue, then run one at a time in
// the engine, which takes no new operation until the current one has loaded
// its last output; a pop or peek reads its bytes one by one through the single
// registered read port of the byte store. Output stalls hold the engine; the
// queue keeps accepting until it is full. Store contents are undefined until
// written; no clearing pass is needed after reset.
`default_nettype none

module byte_ring_fifo import brf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire logic [BYTE_W-1:0] push_byte_i,
  input  wire logic [RUN_W-1:0]  run_length_i,
  input  wire logic [CNT_W-1:0]  skip_length_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [BYTE_W-1:0]      out_byte_o,
  output logic                   byte_valid_o,
  output logic [CNT_W-1:0]       moved_count_o,
  output logic [CNT_W-1:0]       used_count_o,
  output logic [CNT_W-1:0]       free_count_o,
  output logic [CNT_W-1:0]       contiguous_read_o,
  output logic [CNT_W-1:0]       contiguous_write_o,
  output logic                   last_o
);

  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic queue_valid, queue_ready;
  cmd_t queue_cmd;

  brf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .push_byte_i   (push_byte_i),
    .run_length_i  (run_length_i),
    .skip_length_i (skip_length_i),
    .cmd_valid_o   (front_valid),
    .cmd_ready_i   (front_ready),
    .cmd_o         (front_cmd)
  );

  brf_cmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_cmd_i    (front_cmd),
    .out_valid_o (queue_valid),
    .out_ready_i (queue_ready),
    .out_cmd_o   (queue_cmd)
  );

  brf_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_valid_i        (queue_valid),
    .cmd_ready_o        (queue_ready),
    .cmd_i              (queue_cmd),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_byte_o         (out_byte_o),
    .byte_valid_o       (byte_valid_o),
    .moved_count_o      (moved_count_o),
    .used_count_o       (used_count_o),
    .free_count_o       (free_count_o),
    .contiguous_read_o  (contiguous_read_o),
    .contiguous_write_o (contiguous_write_o),
    .last_o             (last_o)
  );

endmodule

`default_nettype wire
